// ===== src/tcb_pkg.sv =====
// ----------------------------------------------------------------------------
// tcb_pkg: shared types and constants of the tagged completion buffer
// Field widths, command and status codes, register indexes and the
// controller/datapath interface structs.
// ----------------------------------------------------------------------------
package tcb_pkg;

  // Default buffer depth
  localparam int DEPTH_DEF = 16;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int TAG_W    = 16;
  localparam int ADDR_W   = 32;
  localparam int THR_W    = 4;
  localparam int TYPE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 5;   // threshold register width

  // Input tdata: tag, address, thread, type, ni_ready (56 bits, 7 bytes)
  localparam int IN_TDATA_W = TAG_W + ADDR_W + THR_W + TYPE_W + 1;

  // Command codes (in_tuser)
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REPLY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEND  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  // Status codes (out_tuser)
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LIMIT = 1'd1;

  // Threshold reset values
  localparam logic [LIMIT_W-1:0] FULL_LIMIT_RST  = 5'd13;
  localparam logic [LIMIT_W-1:0] START_LIMIT_RST = 5'd12;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture accepted input transfer
    logic match;   // tag compare, register first match
    logic apply;   // push or mark serviced
    logic send;    // pick oldest serviced, collapse, write result
  } tcb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic slot_free;  // result register can take a new result
  } tcb_stat_t;

endpackage

// ===== src/tcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcb_ctrl: sequencing controller of the tagged completion buffer
// Steps one item through match, apply and send, holding off the send
// step while the result register is still occupied.
// ----------------------------------------------------------------------------
module tcb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcb_pkg::tcb_stat_t stat,
  output tcb_pkg::tcb_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_APPLY,
    ST_SEND
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_MATCH;
      ST_MATCH: state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_SEND;
      ST_SEND:  if (stat.slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands to the datapath
  assign in_ready  = (state_r == ST_IDLE);
  assign cmd.load  = in_ready && in_valid;
  assign cmd.match = (state_r == ST_MATCH);
  assign cmd.apply = (state_r == ST_APPLY);
  assign cmd.send  = (state_r == ST_SEND) && stat.slot_free;

endmodule

// ===== src/tcb_dp.sv =====
// ----------------------------------------------------------------------------
// tcb_dp: datapath of the tagged completion buffer
// Entry registers, tag compare, serviced pick with collapse, threshold
// registers and the result register.
// ----------------------------------------------------------------------------
module tcb_dp #(
  parameter int BUFFER_DEPTH = tcb_pkg::DEPTH_DEF,
  parameter int CNT_W        = $clog2(BUFFER_DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // controller
  input  tcb_pkg::tcb_cmd_t               cmd,
  output tcb_pkg::tcb_stat_t              stat,
  // input item
  input  logic [tcb_pkg::CMD_W-1:0]       in_cmd,
  input  logic [tcb_pkg::TAG_W-1:0]       in_tag,
  input  logic [tcb_pkg::ADDR_W-1:0]      in_address,
  input  logic [tcb_pkg::THR_W-1:0]       in_thread_id,
  input  logic [tcb_pkg::TYPE_W-1:0]      in_req_type,
  input  logic                            in_ni_ready,
  // configuration writes
  input  logic                            cfg_write,
  input  logic [tcb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcb_pkg::LIMIT_W-1:0]     cfg_data,
  // result
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_sent,
  output logic [tcb_pkg::TAG_W-1:0]       out_sent_tag,
  output logic [tcb_pkg::ADDR_W-1:0]      out_sent_address,
  output logic [tcb_pkg::THR_W-1:0]       out_sent_thread,
  output logic [tcb_pkg::TYPE_W-1:0]      out_sent_type,
  output logic [tcb_pkg::STATUS_W-1:0]    out_status,
  output logic [CNT_W-1:0]                out_occupancy,
  output logic                            out_buffer_full,
  output logic                            out_can_start
);

  localparam int D     = BUFFER_DEPTH;
  localparam int CMP_W = (CNT_W > tcb_pkg::LIMIT_W) ? CNT_W : tcb_pkg::LIMIT_W;

  // Captured item
  logic [tcb_pkg::CMD_W-1:0]  cmd_r;
  logic [tcb_pkg::TAG_W-1:0]  tag_r;
  logic [tcb_pkg::ADDR_W-1:0] addr_r;
  logic [tcb_pkg::THR_W-1:0]  thr_r;
  logic [tcb_pkg::TYPE_W-1:0] typ_r;
  logic                       rdy_r;

  // Entries
  logic [tcb_pkg::TAG_W-1:0]  ent_tag_r   [D];
  logic [tcb_pkg::ADDR_W-1:0] ent_addr_r  [D];
  logic [tcb_pkg::THR_W-1:0]  ent_thr_r   [D];
  logic [tcb_pkg::TYPE_W-1:0] ent_typ_r   [D];
  logic [tcb_pkg::TAG_W-1:0]  ent_tag_nxt [D];
  logic [tcb_pkg::ADDR_W-1:0] ent_addr_nxt[D];
  logic [tcb_pkg::THR_W-1:0]  ent_thr_nxt [D];
  logic [tcb_pkg::TYPE_W-1:0] ent_typ_nxt [D];
  logic [D-1:0]               serv_r;
  logic [D-1:0]               serv_nxt;
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           count_nxt;

  // Per-item control registers
  logic [D-1:0]                  match_oh_r;
  logic                          found_r;
  logic [tcb_pkg::STATUS_W-1:0]  status_r;
  logic                          send_req_r;

  // Thresholds
  logic [tcb_pkg::LIMIT_W-1:0] full_limit_r;
  logic [tcb_pkg::LIMIT_W-1:0] start_limit_r;

  // Result register
  logic                          out_valid_r;
  logic                          sent_r;
  logic [tcb_pkg::TAG_W-1:0]     sent_tag_r;
  logic [tcb_pkg::ADDR_W-1:0]    sent_addr_r;
  logic [tcb_pkg::THR_W-1:0]     sent_thr_r;
  logic [tcb_pkg::TYPE_W-1:0]    sent_typ_r;
  logic [tcb_pkg::STATUS_W-1:0]  res_status_r;
  logic [CNT_W-1:0]              occ_r;
  logic                          full_r;
  logic                          can_r;

  // Combinational helpers
  logic [D-1:0]               held;
  logic [D-1:0]               tag_eq;
  logic [D-1:0]               serv_held;
  logic [D-1:0]               pick;
  logic [D-1:0]               at_or_above;
  logic                       hit;
  logic                       is_full;
  logic [tcb_pkg::TAG_W-1:0]  g_tag;
  logic [tcb_pkg::ADDR_W-1:0] g_addr;
  logic [tcb_pkg::THR_W-1:0]  g_thr;
  logic [tcb_pkg::TYPE_W-1:0] g_typ;

  // Held entries and tag compare, one comparator per entry
  always_comb begin
    for (int i = 0; i < D; i++) begin
      held[i]   = (CNT_W'(i) < count_r);
      tag_eq[i] = held[i] && (ent_tag_r[i] == tag_r);
    end
  end

  assign is_full = (count_r == CNT_W'(D));

  // Oldest serviced entry: isolate lowest set bit, mask from it upward
  assign serv_held   = serv_r & held;
  assign pick        = serv_held & (~serv_held + D'(1));
  assign at_or_above = ~(pick - D'(1));
  assign hit         = send_req_r && (|serv_held);

  // Gather the picked entry
  always_comb begin
    g_tag  = '0;
    g_addr = '0;
    g_thr  = '0;
    g_typ  = '0;
    for (int i = 0; i < D; i++) begin
      g_tag  = g_tag  | ({tcb_pkg::TAG_W{pick[i]}}  & ent_tag_r[i]);
      g_addr = g_addr | ({tcb_pkg::ADDR_W{pick[i]}} & ent_addr_r[i]);
      g_thr  = g_thr  | ({tcb_pkg::THR_W{pick[i]}}  & ent_thr_r[i]);
      g_typ  = g_typ  | ({tcb_pkg::TYPE_W{pick[i]}} & ent_typ_r[i]);
    end
  end

  // Entry update: push, mark serviced, collapse on send
  always_comb begin
    ent_tag_nxt  = ent_tag_r;
    ent_addr_nxt = ent_addr_r;
    ent_thr_nxt  = ent_thr_r;
    ent_typ_nxt  = ent_typ_r;
    serv_nxt     = serv_r;
    count_nxt    = count_r;
    if (cmd.apply) begin
      case (cmd_r)
        tcb_pkg::CMD_PUSH: begin
          if (!is_full) begin
            for (int i = 0; i < D; i++) begin
              if (CNT_W'(i) == count_r) begin
                ent_tag_nxt[i]  = tag_r;
                ent_addr_nxt[i] = addr_r;
                ent_thr_nxt[i]  = thr_r;
                ent_typ_nxt[i]  = typ_r;
                serv_nxt[i]     = 1'b0;
              end
            end
            count_nxt = count_r + CNT_W'(1);
          end
        end
        tcb_pkg::CMD_REPLY: begin
          if (found_r) serv_nxt = serv_r | match_oh_r;
        end
        default: begin
        end
      endcase
    end
    if (cmd.send && hit) begin
      for (int i = 0; i < D - 1; i++) begin
        if (at_or_above[i]) begin
          ent_tag_nxt[i]  = ent_tag_r[i+1];
          ent_addr_nxt[i] = ent_addr_r[i+1];
          ent_thr_nxt[i]  = ent_thr_r[i+1];
          ent_typ_nxt[i]  = ent_typ_r[i+1];
          serv_nxt[i]     = serv_r[i+1];
        end
      end
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Entry storage (contents undefined until written)
  always_ff @(posedge clk) begin
    ent_tag_r  <= ent_tag_nxt;
    ent_addr_r <= ent_addr_nxt;
    ent_thr_r  <= ent_thr_nxt;
    ent_typ_r  <= ent_typ_nxt;
    serv_r     <= serv_nxt;
  end

  // Occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_cmd;
      tag_r  <= in_tag;
      addr_r <= in_address;
      thr_r  <= in_thread_id;
      typ_r  <= in_req_type;
      rdy_r  <= in_ni_ready;
    end
  end

  // Match step: first (oldest) entry with an equal tag
  always_ff @(posedge clk) begin
    if (cmd.match) begin
      match_oh_r <= tag_eq & (~tag_eq + D'(1));
      found_r    <= |tag_eq;
    end
  end

  // Apply step: status and whether a send is attempted
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      case (cmd_r)
        tcb_pkg::CMD_PUSH:  status_r <= is_full ? tcb_pkg::ST_FULL : tcb_pkg::ST_OK;
        tcb_pkg::CMD_REPLY: status_r <= found_r ? tcb_pkg::ST_OK : tcb_pkg::ST_NOT_FOUND;
        default:            status_r <= tcb_pkg::ST_OK;
      endcase
      send_req_r <= rdy_r && (((cmd_r == tcb_pkg::CMD_REPLY) && found_r) ||
                              (cmd_r == tcb_pkg::CMD_SEND));
    end
  end

  // Threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_limit_r  <= tcb_pkg::FULL_LIMIT_RST;
      start_limit_r <= tcb_pkg::START_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tcb_pkg::CFG_FULL_LIMIT:  full_limit_r  <= cfg_data;
        tcb_pkg::CFG_START_LIMIT: start_limit_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.send) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (cmd.send) begin
      sent_r       <= hit;
      sent_tag_r   <= hit ? g_tag  : '0;
      sent_addr_r  <= hit ? g_addr : '0;
      sent_thr_r   <= hit ? g_thr  : '0;
      sent_typ_r   <= hit ? g_typ  : '0;
      res_status_r <= status_r;
      occ_r        <= count_nxt;
      full_r       <= CMP_W'(count_nxt) > CMP_W'(full_limit_r);
      can_r        <= CMP_W'(count_nxt) <= CMP_W'(start_limit_r);
    end
  end

  assign stat.slot_free  = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_sent         = sent_r;
  assign out_sent_tag     = sent_tag_r;
  assign out_sent_address = sent_addr_r;
  assign out_sent_thread  = sent_thr_r;
  assign out_sent_type    = sent_typ_r;
  assign out_status       = res_status_r;
  assign out_occupancy    = occ_r;
  assign out_buffer_full  = full_r;
  assign out_can_start    = can_r;

endmodule

// ===== src/tagged_completion_buffer_top.sv =====
// An ordered buffer of outstanding memory requests. Push appends a request,
// a reply marks the oldest entry with its tag serviced, and a reply or send
// command removes the oldest serviced entry when ni_ready is set, younger
// entries closing the gap. Each input transfer yields exactly one result
// transfer. The result register is loaded through the match, apply and send
// steps (tag match, push or mark, pick and collapse), later while the previous
// result has not been taken; one item is in flight at a time, since each step
// depends on the buffer left by the previous one. in_tready rises at the edge
// that loads the result, so the next input transfer is taken at the following
// edge at the earliest.
// ----------------------------------------------------------------------------
// tagged_completion_buffer_top: tagged completion buffer, top level
// Stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
module tagged_completion_buffer_top #(
  parameter int BUFFER_DEPTH = tcb_pkg::DEPTH_DEF,
  parameter int CNT_W        = $clog2(BUFFER_DEPTH + 1),
  parameter int OUT_BITS     = 1 + tcb_pkg::TAG_W + tcb_pkg::ADDR_W + tcb_pkg::THR_W +
                               tcb_pkg::TYPE_W + CNT_W + 2,
  parameter int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tag[15:0], address[47:16], thread_id[51:48], req_type[54:52], ni_ready[55]
  input  logic [tcb_pkg::IN_TDATA_W-1:0]   in_tdata,
  // cmd[1:0]
  input  logic [tcb_pkg::CMD_W-1:0]        in_tuser,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // sent, sent_tag, sent_address, sent_thread, sent_type, occupancy,
  // buffer_full, can_start, zero pad (from bit 0 up)
  output logic [OUT_TDATA_W-1:0]           out_tdata,
  // status[1:0]
  output logic [tcb_pkg::STATUS_W-1:0]     out_tuser,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tcb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcb_pkg::LIMIT_W-1:0]      cfg_data
);

  tcb_pkg::tcb_cmd_t  cmd;
  tcb_pkg::tcb_stat_t stat;

  logic                          sent;
  logic [tcb_pkg::TAG_W-1:0]     sent_tag;
  logic [tcb_pkg::ADDR_W-1:0]    sent_address;
  logic [tcb_pkg::THR_W-1:0]     sent_thread;
  logic [tcb_pkg::TYPE_W-1:0]    sent_type;
  logic [CNT_W-1:0]              occupancy;
  logic                          buffer_full;
  logic                          can_start;
  logic [OUT_BITS-1:0]           out_payload;

  // Threshold writes are always taken
  assign cfg_ready = 1'b1;

  tcb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcb_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .CNT_W        (CNT_W)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_cmd           (in_tuser),
    .in_tag           (in_tdata[15:0]),
    .in_address       (in_tdata[47:16]),
    .in_thread_id     (in_tdata[51:48]),
    .in_req_type      (in_tdata[54:52]),
    .in_ni_ready      (in_tdata[55]),
    .cfg_write        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_sent         (sent),
    .out_sent_tag     (sent_tag),
    .out_sent_address (sent_address),
    .out_sent_thread  (sent_thread),
    .out_sent_type    (sent_type),
    .out_status       (out_tuser),
    .out_occupancy    (occupancy),
    .out_buffer_full  (buffer_full),
    .out_can_start    (can_start)
  );

  // Result packing, first field in the lowest bits
  assign out_payload = {can_start, buffer_full, occupancy, sent_type, sent_thread,
                        sent_address, sent_tag, sent};
  assign out_tdata   = OUT_TDATA_W'(out_payload);

`ifndef NO_ASSERTIONS
  // Occupancy never exceeds the depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (occupancy <= CNT_W'(BUFFER_DEPTH)))
    else $error("occupancy above buffer depth");

  // A delivery only happens on an item that reported no error
  a_sent_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && sent) |-> (out_tuser == tcb_pkg::ST_OK))
    else $error("delivery with error status");

  // One item at a time: input closes right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in flight");

  // A full-buffer push leaves occupancy at the depth
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == tcb_pkg::ST_FULL)) |->
      (occupancy == CNT_W'(BUFFER_DEPTH)))
    else $error("full status with free space");
`endif

endmodule

// ===== dv/tcb_completion_checker.sv =====
// ----------------------------------------------------------------------------
// tcb_completion_checker: result predictor and scoreboard for the buffer
// Watches the input, result and configuration channels. Every accepted input
// transfer is run through a local copy of the request buffer. The completion
// it should produce is queued and compared field by field with the next
// accepted result transfer.
// ----------------------------------------------------------------------------
module tcb_completion_checker
  import tcb_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int CNT_W       = $clog2(DEPTH + 1),
  parameter int OUT_TDATA_W = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [CMD_W-1:0]       in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [STATUS_W-1:0]    out_tuser,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [LIMIT_W-1:0]     cfg_data,
  output int                     fail_count,
  output int                     pending,
  output int                     n_results,
  output int                     n_sent,
  output int                     n_full,
  output int                     n_miss
);
  timeunit 1ns;
  timeprecision 1ps;

  // input tdata bit offsets
  localparam int I_ADDR = TAG_W;
  localparam int I_THR  = I_ADDR + ADDR_W;
  localparam int I_TYPE = I_THR + THR_W;
  localparam int I_RDY  = I_TYPE + TYPE_W;

  // result tdata bit offsets
  localparam int O_TAG   = 1;
  localparam int O_ADDR  = O_TAG + TAG_W;
  localparam int O_THR   = O_ADDR + ADDR_W;
  localparam int O_TYPE  = O_THR + THR_W;
  localparam int O_OCC   = O_TYPE + TYPE_W;
  localparam int O_FULL  = O_OCC + CNT_W;
  localparam int O_START = O_FULL + 1;

  typedef struct packed {
    logic                sent;
    logic [TAG_W-1:0]    tag;
    logic [ADDR_W-1:0]   addr;
    logic [THR_W-1:0]    thr;
    logic [TYPE_W-1:0]   typ;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    occ;
    logic                full;
    logic                start;
  } completion_t;

  // shadow request buffer, oldest entry at index 0
  logic [TAG_W-1:0]   req_tag  [DEPTH];
  logic [ADDR_W-1:0]  req_addr [DEPTH];
  logic [THR_W-1:0]   req_thr  [DEPTH];
  logic [TYPE_W-1:0]  req_type [DEPTH];
  logic               req_done [DEPTH];
  int                 held;
  logic [LIMIT_W-1:0] full_lim;
  logic [LIMIT_W-1:0] start_lim;

  completion_t completion_q[$];
  int errs, results, sends, full_drops, misses;

  assign fail_count = errs;
  assign n_results  = results;
  assign n_sent     = sends;
  assign n_full     = full_drops;
  assign n_miss     = misses;

  // Remove the oldest serviced entry when the network side can take it
  task automatic deliver_oldest(input logic rdy, inout completion_t r);
    int i, hit;
    hit = -1;
    if (rdy) begin
      for (i = 0; i < held; i++)
        if (hit < 0 && req_done[i]) hit = i;
    end
    if (hit >= 0) begin
      r.sent = 1'b1;
      r.tag  = req_tag[hit];
      r.addr = req_addr[hit];
      r.thr  = req_thr[hit];
      r.typ  = req_type[hit];
      for (i = hit; i + 1 < held; i++) begin
        req_tag[i]  = req_tag[i+1];
        req_addr[i] = req_addr[i+1];
        req_thr[i]  = req_thr[i+1];
        req_type[i] = req_type[i+1];
        req_done[i] = req_done[i+1];
      end
      held--;
    end
  endtask

  // One step of the buffer: update the shadow state, build the completion
  task automatic compute_completion(input logic [CMD_W-1:0] cmd,
                                    input logic [TAG_W-1:0] tag,
                                    input logic [ADDR_W-1:0] addr,
                                    input logic [THR_W-1:0] thr,
                                    input logic [TYPE_W-1:0] typ,
                                    input logic rdy,
                                    output completion_t r);
    int i, hit;
    r = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          req_tag[held]  = tag;
          req_addr[held] = addr;
          req_thr[held]  = thr;
          req_type[held] = typ;
          req_done[held] = 1'b0;
          held++;
        end
      end
      CMD_REPLY: begin
        hit = -1;
        for (i = 0; i < held; i++)
          if (hit < 0 && req_tag[i] == tag) hit = i;
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          req_done[hit] = 1'b1;
          deliver_oldest(rdy, r);
        end
      end
      CMD_SEND: deliver_oldest(rdy, r);
      default: ;
    endcase
    r.occ   = CNT_W'(held);
    r.full  = (held > full_lim);
    r.start = (held <= start_lim);
  endtask

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errs++;
    end
  endfunction

  // Results are checked before new inputs so a same-edge transfer pair stays in order
  always @(posedge clk) begin
    completion_t exp_r, got;
    if (!rst_n) begin
      held      = 0;
      full_lim  = FULL_LIMIT_RST;
      start_lim = START_LIMIT_RST;
      completion_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.sent   = out_tdata[0];
        got.tag    = out_tdata[O_TAG +: TAG_W];
        got.addr   = out_tdata[O_ADDR +: ADDR_W];
        got.thr    = out_tdata[O_THR +: THR_W];
        got.typ    = out_tdata[O_TYPE +: TYPE_W];
        got.status = out_tuser;
        got.occ    = out_tdata[O_OCC +: CNT_W];
        got.full   = out_tdata[O_FULL];
        got.start  = out_tdata[O_START];
        if (completion_q.size() == 0) begin
          $error("result transfer with no item outstanding");
          errs++;
        end else begin
          exp_r = completion_q.pop_front();
          check_field("sent", 64'(exp_r.sent), 64'(got.sent));
          check_field("sent_tag", 64'(exp_r.tag), 64'(got.tag));
          check_field("sent_address", 64'(exp_r.addr), 64'(got.addr));
          check_field("sent_thread", 64'(exp_r.thr), 64'(got.thr));
          check_field("sent_type", 64'(exp_r.typ), 64'(got.typ));
          check_field("status", 64'(exp_r.status), 64'(got.status));
          check_field("occupancy", 64'(exp_r.occ), 64'(got.occ));
          check_field("buffer_full", 64'(exp_r.full), 64'(got.full));
          check_field("can_start", 64'(exp_r.start), 64'(got.start));
          results++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FULL_LIMIT:  full_lim  = cfg_data;
          CFG_START_LIMIT: start_lim = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        compute_completion(in_tuser, in_tdata[TAG_W-1:0], in_tdata[I_ADDR +: ADDR_W],
                           in_tdata[I_THR +: THR_W], in_tdata[I_TYPE +: TYPE_W],
                           in_tdata[I_RDY], exp_r);
        completion_q = {completion_q, exp_r};
        if (exp_r.sent) sends++;
        if (exp_r.status == ST_FULL) full_drops++;
        if (exp_r.status == ST_NOT_FOUND) misses++;
      end
    end
    // registered, so the stimulus side always sees a settled count
    pending <= completion_q.size();
  end

endmodule

// ===== dv/tagged_completion_buffer_top_test.sv =====
// ----------------------------------------------------------------------------
// tagged_completion_buffer_top_test: stimulus and verdict for the buffer
// Directed pushes, replies and sends over the full and empty corners, then
// random request traffic under several threshold settings with random
// backpressure, a long result stall and drain pauses. Checking is done by
// tcb_completion_checker.
// ----------------------------------------------------------------------------
module tagged_completion_buffer_top_test;
  import tcb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int OUT_TDATA_W = ((1 + TAG_W + ADDR_W + THR_W + TYPE_W + CNT_W + 2 + 7) / 8) * 8;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 90;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 20;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]       in_tuser = CMD_NOP;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_FULL_LIMIT;
  logic [LIMIT_W-1:0]     cfg_data = '0;

  int fail_count, pending, n_results, n_sent, n_full, n_miss;

  // stimulus controls
  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;
  int   hold_reqs = 0;
  logic [TAG_W-1:0] recent_tags[$];

  tagged_completion_buffer_top u_top (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  tcb_completion_checker #(.DEPTH(DEPTH), .CNT_W(CNT_W), .OUT_TDATA_W(OUT_TDATA_W)) u_chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending, .n_results, .n_sent, .n_full, .n_miss
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    return ($urandom_range(0, 6) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
  endfunction

  // Result side: random backpressure, plus a long hold when requested
  initial begin
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (!rx_steady && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Offer one item and wait for its transfer; called on a clock edge
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TAG_W-1:0] tag,
                           input logic [ADDR_W-1:0] addr, input logic [THR_W-1:0] thr,
                           input logic [TYPE_W-1:0] typ, input logic rdy);
    int gap;
    gap = (tx_steady || $urandom_range(0, 2) != 0) ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {rdy, typ, thr, addr, tag};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering and wait until every outstanding result has been taken
  task automatic quiesce();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write both thresholds back to back; only called with the block idle
  task automatic write_limits(input logic [LIMIT_W-1:0] full_v,
                              input logic [LIMIT_W-1:0] start_v);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FULL_LIMIT;
    cfg_data  <= full_v;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_START_LIMIT;
    cfg_data  <= start_v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Empty and full corners, duplicate tags, extreme field values
  task automatic run_directed();
    int i;
    logic [TAG_W-1:0] t;
    send_item(CMD_SEND, '0, '0, '0, '0, 1'b1);           // nothing to deliver
    send_item(CMD_REPLY, 16'hBEEF, '0, '0, '0, 1'b1);    // unknown tag
    send_item(CMD_NOP, '1, '1, '1, '1, 1'b1);
    for (i = 0; i < DEPTH; i++) begin
      t = TAG_W'(i) * 16'h1111;
      if (i == 3 || i == 7) t = 16'h1234;                // duplicate tag
      if (i == 0)
        send_item(CMD_PUSH, '0, '0, '0, '0, 1'b0);
      else if (i == DEPTH - 1)
        send_item(CMD_PUSH, '1, '1, '1, '1, 1'b1);
      else
        send_item(CMD_PUSH, t, $urandom, THR_W'($urandom), TYPE_W'($urandom), 1'b0);
    end
    send_item(CMD_PUSH, 16'hABCD, '1, '1, '1, 1'b1);     // buffer full, dropped
    send_item(CMD_REPLY, 16'h1234, '0, '0, '0, 1'b0);    // serviced, network busy
    send_item(CMD_SEND, '0, '0, '0, '0, 1'b0);
    send_item(CMD_SEND, '0, '0, '0, '0, 1'b1);           // delivers older 1234
    send_item(CMD_REPLY, 16'h1234, '0, '0, '0, 1'b1);    // younger duplicate
    send_item(CMD_REPLY, 16'hFFFF, '0, '0, '0, 1'b1);    // youngest entry
    send_item(CMD_REPLY, 16'h0000, '0, '0, '0, 1'b1);    // oldest entry
    send_item(CMD_REPLY, 16'h5555, '0, '0, '0, 1'b0);
    send_item(CMD_SEND, '0, '0, '0, '0, 1'b1);
  endtask

  // Random traffic: replies mostly target recently pushed tags
  task automatic run_random(input int n, input bit with_hold);
    int k, pick, push_pct;
    logic [TAG_W-1:0] tag_base, t;
    logic [CMD_W-1:0] c;
    push_pct = $urandom_range(25, 60);
    tag_base = TAG_W'($urandom);
    for (k = 0; k < n; k++) begin
      if (with_hold && k == 4) hold_reqs <= hold_reqs + 1;
      if (k > 0 && $urandom_range(0, 59) == 0) quiesce();
      pick = $urandom_range(0, 99);
      t = $urandom_range(0, 1) ? {tag_base[TAG_W-1:4], 4'($urandom)} : TAG_W'($urandom);
      if (pick < push_pct) begin
        c = CMD_PUSH;
        recent_tags = {recent_tags, t};
        if (recent_tags.size() > 24) void'(recent_tags.pop_front());
      end else if (pick < push_pct + 25) begin
        c = CMD_REPLY;
        if (recent_tags.size() > 0 && $urandom_range(0, 9) != 0)
          t = recent_tags[$urandom_range(0, recent_tags.size() - 1)];
      end else if (pick < 95) begin
        c = CMD_SEND;
      end else begin
        c = CMD_NOP;
      end
      send_item(c, t, $urandom, THR_W'($urandom), TYPE_W'($urandom),
                $urandom_range(0, 3) != 0);
    end
  endtask

  // Main sequence and verdict
  initial begin
    int phase;
    logic [LIMIT_W-1:0] full_v, start_v;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (phase = 0; phase < N_PHASES; phase++) begin
      quiesce();
      case (phase)
        0:       begin full_v = 5'd0;  start_v = 5'd0;  end
        1:       begin full_v = 5'd16; start_v = 5'd16; end
        2:       begin full_v = 5'd31; start_v = 5'd31; end
        3:       begin full_v = 5'd0;  start_v = 5'd16; end
        4:       begin full_v = 5'd16; start_v = 5'd0;  end
        5:       begin full_v = FULL_LIMIT_RST; start_v = START_LIMIT_RST; end
        default: begin
          full_v  = LIMIT_W'($urandom_range(0, 31));
          start_v = LIMIT_W'($urandom_range(0, 31));
        end
      endcase
      write_limits(full_v, start_v);
      tx_steady <= (phase == 3);
      rx_steady <= (phase == 3);
      run_random(PHASE_ITEMS, phase == 1);
    end
    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d results over %0d threshold settings: %0d deliveries,",
             n_results, N_PHASES + 1, n_sent);
    $display("%0d pushes into a full buffer, %0d replies with unknown tags",
             n_full, n_miss);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
